>>> rtl/mi4_pkg.sv
package mi4_pkg;

  // Handshake status that a multi-cycle arithmetic unit reports back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mi4_status_t;

  // Row order of the three factors of one term of a 3x3 determinant.
  // The result packs the row for factor 0 in [1:0], factor 1 in [3:2] and factor 2 in [5:4].
  function automatic logic [5:0] mi4_perm(input logic [2:0] pi);
    logic [5:0] res;
    case (pi)
      3'd0: res = {2'd2, 2'd1, 2'd0};
      3'd1: res = {2'd1, 2'd2, 2'd0};
      3'd2: res = {2'd2, 2'd0, 2'd1};
      3'd3: res = {2'd0, 2'd2, 2'd1};
      3'd4: res = {2'd1, 2'd0, 2'd2};
      3'd5: res = {2'd0, 2'd1, 2'd2};
      default: res = {2'd2, 2'd1, 2'd0};
    endcase
    return res;
  endfunction

  // True for the odd permutations, whose terms are subtracted.
  function automatic logic mi4_perm_neg(input logic [2:0] pi);
    return (pi == 3'd1) || (pi == 3'd2) || (pi == 3'd5);
  endfunction

endpackage

>>> rtl/mi4_ram.sv
module mi4_ram #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/mi4_mul.sv
module mi4_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 98
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [AW-1:0]          a_i,
  input  logic [BW-1:0]          b_i,
  output mi4_pkg::mi4_status_t   status_o,
  output logic [AW+BW-1:0]       p_o
);
  import mi4_pkg::*;

  localparam int unsigned PW = AW + BW;
  localparam int unsigned CW = $clog2(AW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [AW-1:0] am_q;
  logic [PW-1:0] bs_q, acc_q;
  logic [AW-1:0] a_abs;
  logic [BW-1:0] b_abs;

  // Signed product as magnitudes: one bit of a per cycle, shift and add.
  assign a_abs = a_i[AW-1] ? (~a_i + AW'(1)) : a_i;
  assign b_abs = b_i[BW-1] ? (~b_i + BW'(1)) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(AW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[AW-1] ^ b_i[BW-1];
      am_q  <= a_abs;
      bs_q  <= {{AW{1'b0}}, b_abs};
      acc_q <= '0;
    end else if (busy_q) begin
      if (am_q[0]) begin
        acc_q <= acc_q + bs_q;
      end
      am_q <= am_q >> 1;
      bs_q <= bs_q << 1;
    end
  end

  assign p_o             = neg_q ? (~acc_q + PW'(1)) : acc_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

>>> rtl/mi4_div.sv
module mi4_div #(
  parameter int unsigned NW   = 130,
  parameter int unsigned DENW = 130,
  parameter int unsigned QW   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NW-1:0]        num_i,
  input  logic [DENW-1:0]      den_i,
  output mi4_pkg::mi4_status_t status_o,
  output logic [QW-1:0]        quo_o
);
  import mi4_pkg::*;

  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [NW-1:0] HALF = NW'(1) << (QW - 1);

  logic            busy_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic            neg_q;
  logic [NW-1:0]   nm_q, q_q;
  logic [DENW-1:0] dm_q, rem_q;
  logic [DENW:0]   sh;
  logic            fits;
  logic [NW-1:0]   n_abs, mag, res;
  logic [DENW-1:0] d_abs;

  assign n_abs = num_i[NW-1] ? (~num_i + NW'(1)) : num_i;
  assign d_abs = den_i[DENW-1] ? (~den_i + DENW'(1)) : den_i;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign sh   = {rem_q, nm_q[NW-1]};
  assign fits = sh >= {1'b0, dm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1] ^ den_i[DENW-1];
      nm_q  <= n_abs;
      dm_q  <= d_abs;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DENW'(sh - {1'b0, dm_q}) : sh[DENW-1:0];
      q_q   <= {q_q[NW-2:0], fits};
      nm_q  <= nm_q << 1;
    end
  end

  // Saturate the truncated quotient to the signed output range.
  always_comb begin
    if (neg_q) begin
      mag = (q_q > HALF) ? HALF : q_q;
      res = ~mag + NW'(1);
    end else begin
      mag = (q_q > (HALF - NW'(1))) ? (HALF - NW'(1)) : q_q;
      res = mag;
    end
  end

  assign quo_o         = res[QW-1:0];
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

>>> rtl/matrix4_inverse.sv
// Channel  Direction  Handshake                    Payload
// input    in         in_valid_i / in_ready_o      element_i
// output   out        out_valid_o / out_ready_i    value_o, position_o, singular_o, last_o
//
// Loading takes one word per cycle while in_valid_i is high; the sixteenth word starts the computation and no
// word is taken until all sixteen results have been produced.
// The 16 cofactors take 6 triple products each on one shared shift-add multiplier,
// which then forms the determinant from four more products. Each result then passes
// through the bit-serial divider; for a singular matrix the divider is skipped and the
// result is zero.
// Reset is asynchronous and active low; it clears the sequencer and the load count, the
// element and cofactor memories are not cleared. A stalled output holds the sequencer
// before the next result is loaded into the output register.
module matrix4_inverse #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] element_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] value_o,
  output logic [3:0]            position_o,
  output logic                  singular_o,
  output logic                  last_o
);
  import mi4_pkg::*;

  // Cofactors are exact and need 3 * DATA_WIDTH + 2 signed bits, the determinant one
  // more factor of DATA_WIDTH. The dividend is a cofactor scaled by 2^(2 * FRAC_BITS).
  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned WM = 3 * DW + 2;
  localparam int unsigned WP = DW + WM;
  localparam int unsigned WN = WM + 2 * FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] ST_LOAD = 4'd0;   // taking matrix words
  localparam logic [3:0] ST_FA   = 4'd1;   // read first factor of a term
  localparam logic [3:0] ST_FB   = 4'd2;   // hold first factor, read second
  localparam logic [3:0] ST_FC   = 4'd3;   // first product starts, read third
  localparam logic [3:0] ST_M1   = 4'd4;   // wait first product, start second
  localparam logic [3:0] ST_M2   = 4'd5;   // wait second product, accumulate term
  localparam logic [3:0] ST_DA   = 4'd6;   // read element and cofactor of row zero
  localparam logic [3:0] ST_DB   = 4'd7;   // start determinant product
  localparam logic [3:0] ST_DM   = 4'd8;   // accumulate determinant
  localparam logic [3:0] ST_OA   = 4'd9;   // read cofactor for the next result
  localparam logic [3:0] ST_OB   = 4'd10;  // start division, or take zero if singular
  localparam logic [3:0] ST_OD   = 4'd11;  // wait for the quotient
  localparam logic [3:0] ST_OP   = 4'd12;  // hand the result to the output register

  logic [3:0]    state_q, state_d;
  logic [3:0]    cnt_q, cnt_d;        // words loaded
  logic [3:0]    idx_q, idx_d;        // cofactor, determinant column or result index
  logic [2:0]    pi_q, pi_d;          // term of the 3x3 expansion
  logic [WM-1:0] acc_q, acc_d;        // cofactor being summed
  logic [WP-1:0] det_q, det_d;
  logic          sing_q, sing_d;
  logic [DW-1:0] e0_q, e0_d;
  logic [DW-1:0] res_q, res_d;        // value waiting for the output register

  logic          out_valid_q;
  logic [DW-1:0] value_q;
  logic [3:0]    position_q;
  logic          singular_q, last_q;
  logic          out_load;

  // Element memory.
  logic          e_we, e_re;
  logic [3:0]    e_waddr, e_raddr;
  logic [DW-1:0] e_rdata;
  // Cofactor memory, addressed by {skipped column, skipped row}.
  logic          m_we, m_re;
  logic [3:0]    m_raddr;
  logic [WM-1:0] m_rdata;

  logic          mul_start;
  logic [WM-1:0] mul_b;
  logic [WP-1:0] mul_p;
  mi4_status_t   mul_st;

  logic          div_start;
  logic [WM-1:0] div_m;
  logic [WN-1:0] div_num;
  logic [DW-1:0] div_q;
  mi4_status_t   div_st;

  // Factor addressing: the columns and rows left after the skipped ones.
  logic [1:0]    sc, sr, fi, fcol, frow, fperm;
  logic [5:0]    perm;

  assign sc    = idx_q[3:2];
  assign sr    = idx_q[1:0];
  assign perm  = mi4_perm(pi_q);

  always_comb begin
    case (state_q)
      ST_FB:   fi = 2'd1;
      ST_FC:   fi = 2'd2;
      default: fi = 2'd0;
    endcase
    case (fi)
      2'd1:    fperm = perm[3:2];
      2'd2:    fperm = perm[5:4];
      default: fperm = perm[1:0];
    endcase
    fcol = (fi >= sc) ? (fi + 2'd1) : fi;
    frow = (fperm >= sr) ? (fperm + 2'd1) : fperm;
  end

  mi4_ram #(.W(DW), .DEPTH(16)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (element_i),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // Writes and reads of each memory fall in separate phases, so no forwarding is needed.
  mi4_ram #(.W(WM), .DEPTH(16)) u_cof_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (idx_q),
    .wdata_i (acc_d),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  mi4_mul #(.AW(DW), .BW(WM)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (e_rdata),
    .b_i      (mul_b),
    .status_o (mul_st),
    .p_o      (mul_p)
  );

  // Adjugate entry (col c, row r) is the signed cofactor with row and column swapped.
  assign div_m   = (idx_q[2] ^ idx_q[0]) ? (~m_rdata + WM'(1)) : m_rdata;
  assign div_num = {div_m, {(2 * FRAC_BITS){1'b0}}};

  mi4_div #(.NW(WN), .DENW(WP), .QW(DW)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (det_q),
    .status_o (div_st),
    .quo_o    (div_q)
  );

  assign in_ready_o = (state_q == ST_LOAD);
  assign e_waddr    = cnt_q;
  assign out_load   = (state_q == ST_OP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pi_d      = pi_q;
    acc_d     = acc_q;
    det_d     = det_q;
    sing_d    = sing_q;
    e0_d      = e0_q;
    res_d     = res_q;
    e_we      = 1'b0;
    e_re      = 1'b0;
    e_raddr   = {fcol, frow};
    m_we      = 1'b0;
    m_re      = 1'b0;
    m_raddr   = {idx_q[1:0], idx_q[3:2]};
    mul_start = 1'b0;
    mul_b     = {{(WM - DW){e0_q[DW-1]}}, e0_q};
    div_start = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          e_we  = 1'b1;
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            idx_d   = '0;
            pi_d    = '0;
            acc_d   = '0;
            state_d = ST_FA;
          end
        end
      end
      ST_FA: begin
        e_re    = 1'b1;
        state_d = ST_FB;
      end
      ST_FB: begin
        e0_d    = e_rdata;
        e_re    = 1'b1;
        state_d = ST_FC;
      end
      ST_FC: begin
        mul_start = 1'b1;
        e_re      = 1'b1;
        state_d   = ST_M1;
      end
      ST_M1: begin
        mul_b = mul_p[WM-1:0];
        if (mul_st.done) begin
          mul_start = 1'b1;
          state_d   = ST_M2;
        end
      end
      ST_M2: begin
        if (mul_st.done) begin
          // The first term of each cofactor starts a fresh sum.
          if (pi_q == 3'd0) begin
            acc_d = mul_p[WM-1:0];
          end else begin
            acc_d = mi4_perm_neg(pi_q) ? (acc_q - mul_p[WM-1:0]) : (acc_q + mul_p[WM-1:0]);
          end
          if (pi_q == 3'd5) begin
            m_we = 1'b1;
            pi_d = '0;
            if (idx_q == 4'd15) begin
              idx_d   = '0;
              det_d   = '0;
              state_d = ST_DA;
            end else begin
              idx_d   = idx_q + 4'd1;
              state_d = ST_FA;
            end
          end else begin
            pi_d    = pi_q + 3'd1;
            state_d = ST_FA;
          end
        end
      end
      ST_DA: begin
        e_re    = 1'b1;
        e_raddr = {idx_q[1:0], 2'd0};
        m_re    = 1'b1;
        m_raddr = {idx_q[1:0], 2'd0};
        state_d = ST_DB;
      end
      ST_DB: begin
        mul_b     = m_rdata;
        mul_start = 1'b1;
        state_d   = ST_DM;
      end
      ST_DM: begin
        if (mul_st.done) begin
          det_d = idx_q[0] ? (det_q - mul_p) : (det_q + mul_p);
          if (idx_q[1:0] == 2'd3) begin
            sing_d  = (det_d == '0);
            idx_d   = '0;
            state_d = ST_OA;
          end else begin
            idx_d   = idx_q + 4'd1;
            state_d = ST_DA;
          end
        end
      end
      ST_OA: begin
        m_re    = 1'b1;
        state_d = ST_OB;
      end
      ST_OB: begin
        if (sing_q) begin
          res_d   = '0;
          state_d = ST_OP;
        end else begin
          div_start = 1'b1;
          state_d   = ST_OD;
        end
      end
      ST_OD: begin
        if (div_st.done) begin
          res_d   = div_q;
          state_d = ST_OP;
        end
      end
      ST_OP: begin
        if (out_load) begin
          if (idx_q == 4'd15) begin
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + 4'd1;
            state_d = ST_OA;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      idx_q       <= '0;
      pi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pi_q    <= pi_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    det_q  <= det_d;
    sing_q <= sing_d;
    e0_q   <= e0_d;
    res_q  <= res_d;
    if (out_load) begin
      value_q    <= res_q;
      position_q <= idx_q;
      singular_q <= sing_q;
      last_q     <= (idx_q == 4'd15);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign position_o  = position_q;
  assign singular_o  = singular_q;
  assign last_o      = last_q;

endmodule
